// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro takes a label, the clock, the active-low reset and the checked terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/tsa_pkg.sv =====
`timescale 1ns / 1ps

package tsa_pkg;

    // Default sizes of the table.
    localparam int SLOTS_DEF     = 64;
    localparam int ADDR_BITS_DEF = 64;

    // Fixed widths of the request and response fields.
    localparam int MODE_W   = 3;
    localparam int ADDR_W   = 64;
    localparam int IDX_W    = 6;
    localparam int CAP_W    = 7;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;
    localparam int CTR_W    = 32;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_ACQUIRE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REL_SLOT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REL_ADDR = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SET_PIN  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND     = 3'd4;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_ABSENT = 2'd1,
        STS_FULL   = 2'd2,
        STS_PINNED = 2'd3
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_POP,
        ST_EMIT
    } t_state;

    // One request.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] address;
        logic [IDX_W-1:0]  slot_index;
        logic              pin;
    } t_req;

    // One response.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot;
        logic [TOTAL_W-1:0]  occupancy;
        logic [TOTAL_W-1:0]  pinned_total;
        logic [CTR_W-1:0]    refusal_total;
        logic [CTR_W-1:0]    acquisition_total;
    } t_rsp;

    // Control of the free-slot stack.
    typedef struct packed {
        logic clear;
        logic pop;
        logic push;
    } t_fs_ctl;

endpackage

// ===== hw/rtl/tsa_ram.sv =====
`timescale 1ns / 1ps

module tsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tsa_free_stack.sv =====
`timescale 1ns / 1ps

module tsa_free_stack
    import tsa_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int CAP_RESET = SLOTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_fs_ctl                              i_ctl,
    input  logic [$clog2(SLOTS + 1)-1:0]         i_cap,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_push_slot,
    output logic [$clog2(SLOTS + 1)-1:0]         o_top,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] o_pop_slot
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    logic [CNT_W-1:0] r_top;
    logic [CNT_W-1:0] r_low;
    logic             r_imp;
    logic [SW-1:0]    r_imp_val;
    logic [SW-1:0]    ram_rdata;
    logic [SW-1:0]    top_m1;

    // Positions below the low-water mark have not been written since the
    // last clear, so they still hold their refill value of cap - 1 - position.
    assign top_m1 = SW'(r_top - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= CNT_W'(CAP_RESET);
            r_low <= CNT_W'(CAP_RESET);
        end else if (i_ctl.clear) begin
            r_top <= i_cap;
            r_low <= i_cap;
        end else if (i_ctl.pop) begin
            r_top <= r_top - CNT_W'(1);
            if (r_top <= r_low) begin
                r_low <= r_top - CNT_W'(1);
            end
        end else if (i_ctl.push && (int'(r_top) < SLOTS)) begin
            r_top <= r_top + CNT_W'(1);
        end
        // Remember whether the popped entry comes from the refill pattern.
        if (i_ctl.pop) begin
            r_imp     <= (r_top <= r_low);
            r_imp_val <= SW'(i_cap - r_top);
        end
    end

    tsa_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.push && (int'(r_top) < SLOTS)),
        .i_waddr (SW'(r_top)),
        .i_wdata (i_push_slot),
        .i_raddr (top_m1),
        .o_rdata (ram_rdata)
    );

    assign o_top      = r_top;
    assign o_pop_slot = r_imp ? r_imp_val : ram_rdata;

endmodule

// ===== hw/rtl/tile_slot_allocator_with_pins.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Fully associative slot table with pins and a LIFO free-slot stack. A request
// is taken only while the sequencer is idle and no capacity write is offered,
// and it is worked on alone; a capacity write offered together with a request
// goes first. Acquire, release by address and find search the tag memory
// through one shared comparator, one entry per cycle with a registered read,
// and stop at the first hit: such a request passes through the scan, exec
// and emit states, with a pop state between exec and emit for the free-stack
// read when acquire allocates a new slot. Release by slot, set pin and unknown
// modes need no search and go from exec to emit. A write of the capacity
// register clears the table with no clearing pass; a write of zero is ignored
// and values above SLOTS saturate. The response register lets the next
// request be accepted while a response still waits.
module tile_slot_allocator_with_pins
    import tsa_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEF,
    parameter int ADDRESS_BITS = ADDR_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CAP_W-1:0] i_cfg_data
);

    localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int CAP_RESET = (SLOTS < 64) ? SLOTS : 64;

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_cmp_valid, n_cmp_valid;
    logic [SLOTS-1:0]   r_occ, n_occ;
    logic [SLOTS-1:0]   r_pinf, n_pinf;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [CNT_W-1:0]   r_pins, n_pins;
    logic [CTR_W-1:0]   r_ref, n_ref;
    logic [CTR_W-1:0]   r_acq, n_acq;
    logic [CNT_W-1:0]   r_cap, n_cap;
    logic               r_rsp_valid, n_rsp_valid;

    // Payload state.
    logic [MODE_W-1:0]       r_mode, n_mode;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [IDX_W-1:0]        r_idx, n_idx;
    logic                    r_pin, n_pin;
    logic [SW-1:0]           r_cmp_idx, n_cmp_idx;
    logic                    r_hit, n_hit;
    logic [SW-1:0]           r_hit_slot, n_hit_slot;
    t_status                 r_status, n_status;
    logic [IDX_W-1:0]        r_slot, n_slot;
    t_rsp                    r_rsp, n_rsp;

    // Datapath signals.
    logic [ADDRESS_BITS-1:0] tag_rdata;
    logic                    tag_we;
    logic [SW-1:0]           tag_waddr;
    t_fs_ctl                 fs_ctl;
    logic [SW-1:0]           push_slot;
    logic [CNT_W-1:0]        fs_top;
    logic [SW-1:0]           pop_slot;
    logic                    match_now;
    logic [SW-1:0]           s_tgt;
    logic                    idx_ok;
    logic                    rel_valid;

    assign o_req_ready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // The shared comparator: one stored tag against the requested address.
    assign match_now = r_cmp_valid && r_occ[r_cmp_idx] && (tag_rdata == r_addr);

    // Slot that a release or pin change works on.
    assign s_tgt = ((r_mode == MODE_REL_SLOT) || (r_mode == MODE_SET_PIN))
                   ? SW'(r_idx) : r_hit_slot;
    assign idx_ok    = (int'(r_idx) < int'(r_cap));
    assign rel_valid = (r_mode == MODE_REL_SLOT) ? idx_ok : r_hit;

    // Sequencer: next state and table updates.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cmp_valid = r_cmp_valid;
        n_occ       = r_occ;
        n_pinf      = r_pinf;
        n_used      = r_used;
        n_pins      = r_pins;
        n_ref       = r_ref;
        n_acq       = r_acq;
        n_cap       = r_cap;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_mode      = r_mode;
        n_addr      = r_addr;
        n_idx       = r_idx;
        n_pin       = r_pin;
        n_cmp_idx   = r_cmp_idx;
        n_hit       = r_hit;
        n_hit_slot  = r_hit_slot;
        n_status    = r_status;
        n_slot      = r_slot;
        n_rsp       = r_rsp;
        tag_we      = 1'b0;
        tag_waddr   = pop_slot;
        fs_ctl      = '0;
        push_slot   = s_tgt;

        unique case (r_state)
            ST_IDLE: begin
                // A nonzero capacity write clears the table and refills the free stack.
                if (i_cfg_valid && (i_cfg_data != '0)) begin
                    n_cap        = (int'(i_cfg_data) > SLOTS) ? CNT_W'(SLOTS)
                                                             : CNT_W'(i_cfg_data);
                    n_occ        = '0;
                    n_pinf       = '0;
                    n_used       = '0;
                    n_pins       = '0;
                    fs_ctl.clear = 1'b1;
                end
                if (i_req_valid && o_req_ready) begin
                    n_mode      = i_req.mode;
                    n_addr      = i_req.address[ADDRESS_BITS-1:0];
                    n_idx       = i_req.slot_index;
                    n_pin       = i_req.pin;
                    n_cnt       = '0;
                    n_cmp_valid = 1'b0;
                    n_hit       = 1'b0;
                    if ((i_req.mode == MODE_ACQUIRE) || (i_req.mode == MODE_REL_ADDR)
                            || (i_req.mode == MODE_FIND)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end

            ST_SCAN: begin
                // Issue one tag read per cycle and compare the one read before.
                if (r_cnt < r_cap) begin
                    n_cmp_valid = 1'b1;
                    n_cmp_idx   = r_cnt[SW-1:0];
                    n_cnt       = r_cnt + CNT_W'(1);
                end else begin
                    n_cmp_valid = 1'b0;
                end
                if (match_now) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_cmp_idx;
                    n_state    = ST_EXEC;
                end else if (r_cnt == r_cap) begin
                    n_state = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state  = ST_EMIT;
                n_status = STS_ABSENT;
                n_slot   = '0;
                unique case (r_mode) inside
                    MODE_ACQUIRE: begin
                        if (r_hit) begin
                            if (r_pin && !r_pinf[s_tgt]) begin
                                n_pinf[s_tgt] = 1'b1;
                                n_pins        = r_pins + CNT_W'(1);
                            end
                            n_status = STS_OK;
                            n_slot   = IDX_W'(s_tgt);
                        end else if (fs_top == '0) begin
                            n_ref    = r_ref + CTR_W'(1);
                            n_status = STS_FULL;
                        end else begin
                            fs_ctl.pop = 1'b1;
                            n_state    = ST_POP;
                        end
                    end
                    MODE_REL_SLOT, MODE_REL_ADDR: begin
                        if (rel_valid) begin
                            if (!r_occ[s_tgt]) begin
                                n_status = STS_ABSENT;
                            end else if (r_pinf[s_tgt]) begin
                                n_status = STS_PINNED;
                            end else begin
                                n_occ[s_tgt] = 1'b0;
                                n_used       = r_used - CNT_W'(1);
                                fs_ctl.push  = 1'b1;
                                n_status     = STS_OK;
                                n_slot       = IDX_W'(s_tgt);
                            end
                        end
                    end
                    MODE_SET_PIN: begin
                        if (idx_ok && r_occ[s_tgt]) begin
                            if (r_pinf[s_tgt] != r_pin) begin
                                n_pinf[s_tgt] = r_pin;
                                n_pins = r_pin ? (r_pins + CNT_W'(1)) : (r_pins - CNT_W'(1));
                            end
                            n_status = STS_OK;
                            n_slot   = IDX_W'(s_tgt);
                        end
                    end
                    MODE_FIND: begin
                        if (r_hit) begin
                            n_status = STS_OK;
                            n_slot   = IDX_W'(s_tgt);
                        end
                    end
                    default: begin
                        n_status = STS_ABSENT;
                    end
                endcase
            end

            ST_POP: begin
                // The popped slot takes the new tag.
                tag_we           = 1'b1;
                tag_waddr        = pop_slot;
                n_occ[pop_slot]  = 1'b1;
                n_pinf[pop_slot] = r_pin;
                n_used           = r_used + CNT_W'(1);
                n_pins           = r_pins + CNT_W'(r_pin);
                n_acq            = r_acq + CTR_W'(1);
                n_status         = STS_OK;
                n_slot           = IDX_W'(pop_slot);
                n_state          = ST_EMIT;
            end

            ST_EMIT: begin
                // Load the response register once it is free.
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp.status            = r_status;
                    n_rsp.slot              = r_slot;
                    n_rsp.occupancy         = TOTAL_W'(r_used);
                    n_rsp.pinned_total      = TOTAL_W'(r_pins);
                    n_rsp.refusal_total     = r_ref;
                    n_rsp.acquisition_total = r_acq;
                    n_rsp_valid             = 1'b1;
                    n_state                 = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_cmp_valid <= 1'b0;
            r_occ       <= '0;
            r_pinf      <= '0;
            r_used      <= '0;
            r_pins      <= '0;
            r_ref       <= '0;
            r_acq       <= '0;
            r_cap       <= CNT_W'(CAP_RESET);
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cmp_valid <= n_cmp_valid;
            r_occ       <= n_occ;
            r_pinf      <= n_pinf;
            r_used      <= n_used;
            r_pins      <= n_pins;
            r_ref       <= n_ref;
            r_acq       <= n_acq;
            r_cap       <= n_cap;
            r_rsp_valid <= n_rsp_valid;
        end
        r_mode     <= n_mode;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_pin      <= n_pin;
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_hit_slot <= n_hit_slot;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_rsp      <= n_rsp;
    end

    // Tag memory, read by the search at the scan counter.
    tsa_ram #(
        .WIDTH (ADDRESS_BITS),
        .DEPTH (SLOTS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (r_addr),
        .i_raddr (r_cnt[SW-1:0]),
        .o_rdata (tag_rdata)
    );

    // Free-slot stack.
    tsa_free_stack #(
        .SLOTS     (SLOTS),
        .CAP_RESET (CAP_RESET)
    ) u_free_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (fs_ctl),
        .i_cap       (n_cap),
        .i_push_slot (push_slot),
        .o_top       (fs_top),
        .o_pop_slot  (pop_slot)
    );

    // Every slot is either occupied or on the free stack, except while a pop
    // is being completed.
    `ASSERT_IMPLY(a_slot_balance, i_clk, i_rst_n, (r_state != ST_POP), (({1'b0, r_used} + {1'b0, fs_top}) == {1'b0, r_cap}))

    // Pinned slots are a subset of the occupied ones.
    `ASSERT_ALWAYS(a_pins_le_used, i_clk, i_rst_n, (r_pins <= r_used))

    // The search never runs past the capacity.
    `ASSERT_IMPLY(a_scan_bound, i_clk, i_rst_n, (r_state == ST_SCAN), (r_cnt <= r_cap))

    // A finished request always lands in the response register.
    `ASSERT_NEXT(a_emit_done, i_clk, i_rst_n, ((r_state == ST_EMIT) && (!r_rsp_valid || i_rsp_ready)), (r_rsp_valid && (r_state == ST_IDLE)))

endmodule
